@@ hdl/e2q_pkg.sv @@
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants, types and arithmetic helpers for the Euler angle to
// quaternion converter: CORDIC arctangent table, Q30 constants, lane types.
// ----------------------------------------------------------------------------
`default_nettype none

package e2q_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int QUAT_BITS_DEF  = 16;

  localparam int CORDIC_STEPS = 30;
  localparam int NUM_LANES    = 3;

  // Lane order: pitch, roll, yaw
  localparam int LANE_PITCH = 0;
  localparam int LANE_ROLL  = 1;
  localparam int LANE_YAW   = 2;

  // Rotation datapath widths (Q30 plus headroom)
  localparam int XY_W = 33;
  localparam int Z_W  = 33;
  localparam int TRIG_W = 32;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [XY_W-1:0] ONE_Q30         = 33'sd1073741824;

  // atan(2^-i), binary angle with 2^31 = pi
  localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41721,     33'sd20860,
    33'sd10430,     33'sd5215,      33'sd2607,      33'sd1303,
    33'sd651,       33'sd325,       33'sd162,       33'sd81,
    33'sd40,        33'sd20,        33'sd10,        33'sd5,
    33'sd2,         33'sd1
  };

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } trig_t;

  // Q30 x Q30 product, rounded half up back to Q30
  function automatic logic signed [TRIG_W-1:0] mul_q30(
    input logic signed [TRIG_W-1:0] a,
    input logic signed [TRIG_W-1:0] b
  );
    logic signed [63:0] p;
    p = a * b + (64'sd1 <<< 29);
    return TRIG_W'(p >>> 30);
  endfunction

endpackage

`default_nettype wire

@@ hdl/e2q_if.sv @@
// ----------------------------------------------------------------------------
// e2q_if
// Valid/ready channels of the converter: angle input and quaternion output.
// ----------------------------------------------------------------------------
`default_nettype none

interface e2q_in_if
  import e2q_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] roll_angle;
  logic signed [ANGLE_BITS-1:0] yaw_angle;

  modport source (output valid, output pitch_angle, output roll_angle,
                  output yaw_angle, input ready);
  modport sink   (input valid, input pitch_angle, input roll_angle,
                  input yaw_angle, output ready);
endinterface

interface e2q_out_if
  import e2q_pkg::*;
#(
  parameter int QUAT_BITS = QUAT_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [QUAT_BITS-1:0] quat_x;
  logic signed [QUAT_BITS-1:0] quat_y;
  logic signed [QUAT_BITS-1:0] quat_z;
  logic signed [QUAT_BITS-1:0] quat_w;

  modport source (output valid, output quat_x, output quat_y, output quat_z,
                  output quat_w, input ready);
  modport sink   (input valid, input quat_x, input quat_y, input quat_z,
                  input quat_w, output ready);
endinterface

`default_nettype wire

@@ hdl/e2q_cordic.sv @@
// ----------------------------------------------------------------------------
// e2q_cordic
// Three-lane pipelined CORDIC rotator: one micro-rotation per stage, then a
// clamp stage giving sine and cosine in Q30 for each half angle.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_cordic
  import e2q_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  src_valid,
  input  wire logic signed [Z_W-1:0] src_angle [NUM_LANES],
  output      logic                  dst_valid,
  output      trig_t                 dst_trig [NUM_LANES]
);

  logic                   v_r [CORDIC_STEPS];
  logic signed [XY_W-1:0] x_r [CORDIC_STEPS][NUM_LANES];
  logic signed [XY_W-1:0] y_r [CORDIC_STEPS][NUM_LANES];
  logic signed [Z_W-1:0]  z_r [CORDIC_STEPS][NUM_LANES];

  logic  trig_valid_r;
  trig_t trig_r [NUM_LANES];

  function automatic logic signed [TRIG_W-1:0] clamp_unit(
    input logic signed [XY_W-1:0] v
  );
    logic signed [XY_W-1:0] c;
    c = v;
    if (v > ONE_Q30) c = ONE_Q30;
    if (v < -ONE_Q30) c = -ONE_Q30;
    return TRIG_W'(c);
  endfunction

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    logic                   vs;
    logic signed [XY_W-1:0] xs [NUM_LANES];
    logic signed [XY_W-1:0] ys [NUM_LANES];
    logic signed [Z_W-1:0]  zs [NUM_LANES];
    logic signed [XY_W-1:0] x_nxt [NUM_LANES];
    logic signed [XY_W-1:0] y_nxt [NUM_LANES];
    logic signed [Z_W-1:0]  z_nxt [NUM_LANES];

    if (i == 0) begin : g_first
      always_comb begin
        vs = src_valid;
        for (int l = 0; l < NUM_LANES; l++) begin
          xs[l] = CORDIC_GAIN_Q30;
          ys[l] = '0;
          zs[l] = src_angle[l];
        end
      end
    end else begin : g_next
      always_comb begin
        vs = v_r[i-1];
        for (int l = 0; l < NUM_LANES; l++) begin
          xs[l] = x_r[i-1][l];
          ys[l] = y_r[i-1][l];
          zs[l] = z_r[i-1][l];
        end
      end
    end

    // rotate toward zero residual angle
    always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
        if (zs[l] >= 0) begin
          x_nxt[l] = xs[l] - (ys[l] >>> i);
          y_nxt[l] = ys[l] + (xs[l] >>> i);
          z_nxt[l] = zs[l] - ATAN_TAB[i];
        end else begin
          x_nxt[l] = xs[l] + (ys[l] >>> i);
          y_nxt[l] = ys[l] - (xs[l] >>> i);
          z_nxt[l] = zs[l] + ATAN_TAB[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vs;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          x_r[i][l] <= x_nxt[l];
          y_r[i][l] <= y_nxt[l];
          z_r[i][l] <= z_nxt[l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_valid_r <= 1'b0;
    end else if (en) begin
      trig_valid_r <= v_r[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        trig_r[l].s <= clamp_unit(y_r[CORDIC_STEPS-1][l]);
        trig_r[l].c <= clamp_unit(x_r[CORDIC_STEPS-1][l]);
      end
    end
  end

  assign dst_valid = trig_valid_r;
  assign dst_trig  = trig_r;

endmodule

`default_nettype wire

@@ hdl/euler_to_quaternion.sv @@
// The converter takes one pitch/roll/yaw item per clock while in_ch.ready is
// high and returns one quaternion item per item, in order, through 30 CORDIC
// micro-rotation stages and a clamp stage for the half-angle sines and
// cosines (three lanes side by side), two multiplier stages for the triple
// products, one sum/round/saturate stage and the output register. Sustained
// rate is one item per cycle while the sink takes them. A skid register
// behind the output absorbs one item when the sink stalls; in_ch.ready comes
// from it and drops in the cycle after an item meets a full, stalled output.
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Euler angles (binary angle, full scale = +/-pi) to a unit quaternion in
// signed Q1.(QUAT_BITS-1), saturating +1.0 to the largest code.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_quaternion
  import e2q_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int QUAT_BITS  = QUAT_BITS_DEF
)(
  input wire logic  clk,
  input wire logic  rst_n,
  e2q_in_if.sink    in_ch,
  e2q_out_if.source out_ch
);

  localparam int ANG_SH = 32 - ANGLE_BITS;
  localparam int OUT_SH = 31 - QUAT_BITS;
  localparam int RSH    = (OUT_SH > 0) ? OUT_SH : 0;
  localparam int RND_SH = (OUT_SH > 0) ? OUT_SH - 1 : 0;
  localparam int QW     = 36;
  localparam logic signed [QW-1:0] RND  = (OUT_SH > 0) ? (36'sd1 <<< RND_SH) : 36'sd0;
  localparam logic signed [QW-1:0] QHI  = (36'sd1 <<< (QUAT_BITS - 1)) - 36'sd1;
  localparam logic signed [QW-1:0] QLO  = -(36'sd1 <<< (QUAT_BITS - 1));

  logic en;

  // ---- angle scaling: to 32-bit binary angle, then halve ----
  logic signed [ANGLE_BITS-1:0] ang_in [NUM_LANES];
  logic signed [31:0]           ang32 [NUM_LANES];
  logic signed [Z_W-1:0]        half_ang [NUM_LANES];

  always_comb begin
    ang_in[LANE_PITCH] = in_ch.pitch_angle;
    ang_in[LANE_ROLL]  = in_ch.roll_angle;
    ang_in[LANE_YAW]   = in_ch.yaw_angle;
    for (int l = 0; l < NUM_LANES; l++) begin
      ang32[l]    = 32'(ang_in[l]) <<< ANG_SH;
      half_ang[l] = Z_W'(ang32[l]) >>> 1;
    end
  end

  logic  cs_valid;
  trig_t cs [NUM_LANES];

  e2q_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .src_valid (in_ch.valid),
    .src_angle (half_ang),
    .dst_valid (cs_valid),
    .dst_trig  (cs)
  );

  // ---- first products ----
  logic                     m1_valid_r;
  logic signed [TRIG_W-1:0] a_r, b_r, c_r, d_r, cy_r, sy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= mul_q30(cs[LANE_ROLL].s, cs[LANE_PITCH].c);
      b_r  <= mul_q30(cs[LANE_ROLL].c, cs[LANE_PITCH].s);
      c_r  <= mul_q30(cs[LANE_ROLL].c, cs[LANE_PITCH].c);
      d_r  <= mul_q30(cs[LANE_ROLL].s, cs[LANE_PITCH].s);
      cy_r <= cs[LANE_YAW].c;
      sy_r <= cs[LANE_YAW].s;
    end
  end

  // ---- second products ----
  logic                     m2_valid_r;
  logic signed [TRIG_W-1:0] acy_r, asy_r, bcy_r, bsy_r, ccy_r, csy_r, dcy_r, dsy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      acy_r <= mul_q30(a_r, cy_r);
      asy_r <= mul_q30(a_r, sy_r);
      bcy_r <= mul_q30(b_r, cy_r);
      bsy_r <= mul_q30(b_r, sy_r);
      ccy_r <= mul_q30(c_r, cy_r);
      csy_r <= mul_q30(c_r, sy_r);
      dcy_r <= mul_q30(d_r, cy_r);
      dsy_r <= mul_q30(d_r, sy_r);
    end
  end

  // ---- sums, rounding and saturation ----
  function automatic logic signed [QUAT_BITS-1:0] quat_out(
    input logic signed [TRIG_W:0] q30
  );
    logic signed [QW-1:0] v;
    if (OUT_SH >= 0) v = (QW'(q30) + RND) >>> RSH;
    else             v = QW'(q30) <<< 1;
    if (v > QHI) v = QHI;
    if (v < QLO) v = QLO;
    return QUAT_BITS'(v);
  endfunction

  logic signed [TRIG_W:0] qx_sum, qy_sum, qz_sum, qw_sum;

  always_comb begin
    qx_sum = (TRIG_W+1)'(acy_r) - (TRIG_W+1)'(bsy_r);
    qy_sum = (TRIG_W+1)'(bcy_r) + (TRIG_W+1)'(asy_r);
    qz_sum = (TRIG_W+1)'(csy_r) - (TRIG_W+1)'(dcy_r);
    qw_sum = (TRIG_W+1)'(ccy_r) + (TRIG_W+1)'(dsy_r);
  end

  logic                        s_valid_r;
  logic signed [QUAT_BITS-1:0] sx_r, sy_q_r, sz_r, sw_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r   <= quat_out(qx_sum);
      sy_q_r <= quat_out(qy_sum);
      sz_r   <= quat_out(qz_sum);
      sw_r   <= quat_out(qw_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
      m2_valid_r <= 1'b0;
      s_valid_r  <= 1'b0;
    end else if (en) begin
      m1_valid_r <= cs_valid;
      m2_valid_r <= m1_valid_r;
      s_valid_r  <= m2_valid_r;
    end
  end

  // ---- output register with skid ----
  logic                        out_valid_r, skid_valid_r;
  logic signed [QUAT_BITS-1:0] ox_r, oy_r, oz_r, ow_r;
  logic signed [QUAT_BITS-1:0] kx_r, ky_r, kz_r, kw_r;
  logic                        push, load_out, load_skid;

  assign en        = !skid_valid_r;
  assign push      = en && s_valid_r;
  assign load_out  = push && (!out_valid_r || out_ch.ready);
  assign load_skid = push && out_valid_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ch.ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r && out_ch.ready) begin
      ox_r <= kx_r;
      oy_r <= ky_r;
      oz_r <= kz_r;
      ow_r <= kw_r;
    end else if (load_out) begin
      ox_r <= sx_r;
      oy_r <= sy_q_r;
      oz_r <= sz_r;
      ow_r <= sw_r;
    end
    if (load_skid) begin
      kx_r <= sx_r;
      ky_r <= sy_q_r;
      kz_r <= sz_r;
      kw_r <= sw_r;
    end
  end

  assign in_ch.ready  = en;
  assign out_ch.valid = out_valid_r;
  assign out_ch.quat_x = ox_r;
  assign out_ch.quat_y = oy_r;
  assign out_ch.quat_z = oz_r;
  assign out_ch.quat_w = ow_r;

`ifndef NO_ASSERTIONS
  a_skid_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ch.ready))
    else $error("skid filled while output was free");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item with output empty");

  a_stalled_push_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !out_ch.ready) |=> skid_valid_r)
    else $error("item dropped while output stalled");

  a_drain_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ch.ready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid item lost on drain");
`endif

endmodule

`default_nettype wire
